// ----- sv/hpmc_pkg.sv -----
// Shared constants and types for the half-pel motion compensation block.
// Used by the channel interfaces, the interpolation datapath and the top level.
package hpmc_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 16;
    localparam int MAX_HEIGHT = 16;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    // Block geometry, clipped to the largest supported window
    localparam int BLK_W_NARROW = (8 > MAX_WIDTH) ? MAX_WIDTH : 8;
    localparam int BLK_W_WIDE   = (16 > MAX_WIDTH) ? MAX_WIDTH : 16;
    localparam int BLK_H_SHORT  = (4 > MAX_HEIGHT) ? MAX_HEIGHT : 4;
    localparam int BLK_H_MID    = (8 > MAX_HEIGHT) ? MAX_HEIGHT : 8;
    localparam int BLK_H_TALL   = (16 > MAX_HEIGHT) ? MAX_HEIGHT : 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_BLOCK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_CODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 3'd4;

    // Height codes
    localparam logic [1:0] HEIGHT_4  = 2'd0;
    localparam logic [1:0] HEIGHT_8  = 2'd1;
    localparam logic [1:0] HEIGHT_16 = 2'd2;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic half_x;
        logic half_y;
        logic average_mode;
    } interp_mode_t;

endpackage

// ----- sv/hpmc_if.sv -----
// Valid/ready channels of the half-pel motion compensation block.
// Depends on hpmc_pkg for the pixel type.
interface hpmc_ref_if;
    logic              valid;
    logic              ready;
    hpmc_pkg::pixel_t  ref_pixel;
    hpmc_pkg::pixel_t  dest_pixel;

    modport source (output valid, output ref_pixel, output dest_pixel, input ready);
    modport sink   (input valid, input ref_pixel, input dest_pixel, output ready);
endinterface

interface hpmc_pred_if;
    logic              valid;
    logic              ready;
    hpmc_pkg::pixel_t  pred_pixel;
    logic              block_end;

    modport source (output valid, output pred_pixel, output block_end, input ready);
    modport sink   (input valid, input pred_pixel, input block_end, output ready);
endinterface

// ----- sv/halfpel_motion_compensation.sv -----
// Half-pel motion compensation: reference window pixels in, prediction pixels out.
// Depends on hpmc_pkg, the channels in hpmc_if and the datapath in hpmc_interp.
//
// Reference window pixels enter in raster order, one word per cycle while ref_ch.ready is
// high, each with the destination pixel its output overwrites; a (W+half_x) by (H+half_y)
// window yields W*H prediction words, the leading column and row of an interpolated window
// giving none. The interpolation is combinational from the row store and neighbour
// registers, and its result is registered in the output register, or in the skid entry when
// the output is stalled, so the block sustains one pixel per clock while the output is not
// stalled. A two-entry output stage lets a new word in while a result waits to be taken.
// Write the configuration only between blocks.
module halfpel_motion_compensation
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hpmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hpmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    hpmc_ref_if.sink                            ref_ch,
    hpmc_pred_if.source                         pred_ch
);

    localparam int CW = hpmc_pkg::COUNT_W;

    // Configuration
    logic       wide_block_reg;
    logic [1:0] height_code_reg;
    logic       half_x_reg;
    logic       half_y_reg;
    logic       average_mode_reg;

    // Window state
    hpmc_pkg::pixel_t row_store_reg [0:hpmc_pkg::MAX_WIDTH];
    hpmc_pkg::pixel_t left_pixel_reg;
    hpmc_pkg::pixel_t above_left_pixel_reg;
    logic [CW-1:0]    column_count_reg;
    logic [CW-1:0]    column_count_next;
    logic [CW-1:0]    row_count_reg;
    logic [CW-1:0]    row_count_next;

    // Output stage
    logic             out_valid_reg;
    hpmc_pkg::pixel_t out_pixel_reg;
    logic             out_end_reg;
    logic             skid_valid_reg;
    hpmc_pkg::pixel_t skid_pixel_reg;
    logic             skid_end_reg;

    logic                   accept;
    logic                   emit;
    logic                   push;
    logic                   out_free;
    logic [CW-1:0]          width_pix;
    logic [CW-1:0]          height_pix;
    logic [CW-1:0]          last_col;
    logic [CW-1:0]          last_row;
    logic                   at_row_end;
    logic                   at_block_end;
    hpmc_pkg::pixel_t       above_pixel;
    hpmc_pkg::pixel_t       pred_pixel;
    hpmc_pkg::interp_mode_t mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_block_reg   <= 1'b0;
            height_code_reg  <= hpmc_pkg::HEIGHT_8;
            half_x_reg       <= 1'b0;
            half_y_reg       <= 1'b0;
            average_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpmc_pkg::REG_WIDE_BLOCK:   wide_block_reg   <= cfg_data[0];
                hpmc_pkg::REG_HEIGHT_CODE:  height_code_reg  <= cfg_data[1:0];
                hpmc_pkg::REG_HALF_X:       half_x_reg       <= cfg_data[0];
                hpmc_pkg::REG_HALF_Y:       half_y_reg       <= cfg_data[0];
                hpmc_pkg::REG_AVERAGE_MODE: average_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        width_pix = wide_block_reg ? CW'(hpmc_pkg::BLK_W_WIDE) : CW'(hpmc_pkg::BLK_W_NARROW);
        case (height_code_reg)
            hpmc_pkg::HEIGHT_4: height_pix = CW'(hpmc_pkg::BLK_H_SHORT);
            hpmc_pkg::HEIGHT_8: height_pix = CW'(hpmc_pkg::BLK_H_MID);
            default:            height_pix = CW'(hpmc_pkg::BLK_H_TALL);
        endcase
        last_col = width_pix + CW'(half_x_reg) - CW'(1);
        last_row = height_pix + CW'(half_y_reg) - CW'(1);

        at_row_end   = column_count_reg >= last_col;
        at_block_end = at_row_end && (row_count_reg >= last_row);
        emit         = (column_count_reg >= CW'(half_x_reg))
                    && (row_count_reg >= CW'(half_y_reg));

        // the count never passes the store depth; guard the unused codes anyway
        if (column_count_reg <= CW'(hpmc_pkg::MAX_WIDTH))
        begin
            above_pixel = row_store_reg[column_count_reg];
        end
        else
        begin
            above_pixel = '0;
        end

        if (at_block_end)
        begin
            column_count_next = '0;
            row_count_next    = '0;
        end
        else if (at_row_end)
        begin
            column_count_next = '0;
            row_count_next    = row_count_reg + CW'(1);
        end
        else
        begin
            column_count_next = column_count_reg + CW'(1);
            row_count_next    = row_count_reg;
        end

        mode.half_x       = half_x_reg;
        mode.half_y       = half_y_reg;
        mode.average_mode = average_mode_reg;
    end

    hpmc_interp u_interp
    (
        .ref_pixel        (ref_ch.ref_pixel),
        .dest_pixel       (ref_ch.dest_pixel),
        .left_pixel       (left_pixel_reg),
        .above_pixel      (above_pixel),
        .above_left_pixel (above_left_pixel_reg),
        .mode             (mode),
        .pred_pixel       (pred_pixel)
    );

    assign ref_ch.ready = !skid_valid_reg;
    assign accept       = ref_ch.valid && !skid_valid_reg;
    assign push         = accept && emit;
    assign out_free     = !out_valid_reg || pred_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pixel_reg       <= '0;
            above_left_pixel_reg <= '0;
            column_count_reg     <= '0;
            row_count_reg        <= '0;
        end
        else if (accept)
        begin
            left_pixel_reg       <= ref_ch.ref_pixel;
            above_left_pixel_reg <= above_pixel;
            column_count_reg     <= column_count_next;
            row_count_reg        <= row_count_next;
        end
    end

    // row store holds no reset; every entry is written before it is read
    always_ff @(posedge clk)
    begin
        if (accept && (column_count_reg <= CW'(hpmc_pkg::MAX_WIDTH)))
        begin
            row_store_reg[column_count_reg] <= ref_ch.ref_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // refill the output from the skid entry first to keep order
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_pixel_reg <= skid_pixel_reg;
                out_end_reg   <= skid_end_reg;
            end
            else
            begin
                out_pixel_reg <= pred_pixel;
                out_end_reg   <= at_block_end;
            end
        end
        if (!out_free && push)
        begin
            skid_pixel_reg <= pred_pixel;
            skid_end_reg   <= at_block_end;
        end
    end

    assign pred_ch.valid      = out_valid_reg;
    assign pred_ch.pred_pixel = out_pixel_reg;
    assign pred_ch.block_end  = out_end_reg;

endmodule

// ----- sv/hpmc_interp.sv -----
// Half-pel interpolation and destination averaging for one output pixel.
// Depends on hpmc_pkg for the pixel and mode types.
module hpmc_interp
(
    input  hpmc_pkg::pixel_t       ref_pixel,
    input  hpmc_pkg::pixel_t       dest_pixel,
    input  hpmc_pkg::pixel_t       left_pixel,
    input  hpmc_pkg::pixel_t       above_pixel,
    input  hpmc_pkg::pixel_t       above_left_pixel,
    input  hpmc_pkg::interp_mode_t mode,
    output hpmc_pkg::pixel_t       pred_pixel
);

    localparam int SUM_W = hpmc_pkg::PIX_W + 2;

    logic [SUM_W-1:0]      sum4;
    logic [SUM_W-1:0]      sum_h;
    logic [SUM_W-1:0]      sum_v;
    logic [SUM_W-1:0]      sum_avg;
    hpmc_pkg::pixel_t      interp;

    always_comb
    begin
        sum4  = SUM_W'(above_left_pixel) + SUM_W'(above_pixel) + SUM_W'(left_pixel)
              + SUM_W'(ref_pixel) + SUM_W'(2);
        sum_h = SUM_W'(left_pixel) + SUM_W'(ref_pixel) + SUM_W'(1);
        sum_v = SUM_W'(above_pixel) + SUM_W'(ref_pixel) + SUM_W'(1);

        if (mode.half_x && mode.half_y)
        begin
            interp = sum4[SUM_W-1:2];
        end
        else if (mode.half_x)
        begin
            interp = sum_h[SUM_W-2:1];
        end
        else if (mode.half_y)
        begin
            interp = sum_v[SUM_W-2:1];
        end
        else
        begin
            interp = ref_pixel;
        end

        // bidirectional style: round-average with what is already there
        sum_avg = SUM_W'(dest_pixel) + SUM_W'(interp) + SUM_W'(1);
        pred_pixel = mode.average_mode ? sum_avg[SUM_W-2:1] : interp;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for halfpel_motion_compensation: streams reference windows, predicts
// every prediction word in step with the inputs and compares each word as it leaves.
// Depends on hpmc_pkg, the channel interfaces in hpmc_if and the block itself.
module tb_top;

    localparam logic [1:0] HEIGHT_RESERVED = 2'd3;
    localparam int RANDOM_WORDS = 100;

    typedef struct {
        hpmc_pkg::pixel_t pel;
        logic             last;
    } pred_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [hpmc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hpmc_pkg::CFG_DATA_W-1:0] cfg_data;

    hpmc_ref_if  ref_ch ();
    hpmc_pred_if pred_ch ();

    halfpel_motion_compensation DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ref_ch    (ref_ch),
        .pred_ch   (pred_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the block: geometry registers, previous window row, neighbours, position
    logic             cfg_wide  = 1'b0;
    logic [1:0]       cfg_hcode = hpmc_pkg::HEIGHT_8;
    logic             cfg_hx    = 1'b0;
    logic             cfg_hy    = 1'b0;
    logic             cfg_avg   = 1'b0;
    hpmc_pkg::pixel_t prev_row [0:hpmc_pkg::MAX_WIDTH];
    hpmc_pkg::pixel_t left_pel       = '0;
    hpmc_pkg::pixel_t above_left_pel = '0;
    int               col_pos        = 0;
    int               row_pos        = 0;

    pred_word_t expected_pels [$];

    int  mismatches    = 0;
    int  words_sent    = 0;
    int  pels_checked  = 0;
    int  windows_seen  = 0;
    int  regeometries  = 0;
    bit  src_gaps_on   = 1'b0;
    bit  snk_stall_on  = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic hpmc_pkg::pixel_t rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return hpmc_pkg::pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the shadow by one accepted reference word and queue its prediction, if any
    task automatic predict_pel(input hpmc_pkg::pixel_t rp, input hpmc_pkg::pixel_t dp);
        int col;
        int last_col;
        int last_row;
        int above;
        int pel;
        logic row_end;
        logic win_end;
        logic emits;
        col = col_pos % (hpmc_pkg::MAX_WIDTH + 1);
        last_col = (cfg_wide ? hpmc_pkg::BLK_W_WIDE : hpmc_pkg::BLK_W_NARROW)
                 + int'(cfg_hx) - 1;
        case (cfg_hcode)
            hpmc_pkg::HEIGHT_4: last_row = hpmc_pkg::BLK_H_SHORT;
            hpmc_pkg::HEIGHT_8: last_row = hpmc_pkg::BLK_H_MID;
            default:            last_row = hpmc_pkg::BLK_H_TALL;
        endcase
        last_row = last_row + int'(cfg_hy) - 1;
        above = prev_row[col];
        row_end = (col_pos >= last_col);
        win_end = row_end && (row_pos >= last_row);
        emits = (col_pos >= int'(cfg_hx)) && (row_pos >= int'(cfg_hy));

        if (cfg_hx && cfg_hy)
            pel = (int'(above_left_pel) + above + int'(left_pel) + int'(rp) + 2) >> 2;
        else if (cfg_hx)
            pel = (int'(left_pel) + int'(rp) + 1) >> 1;
        else if (cfg_hy)
            pel = (above + int'(rp) + 1) >> 1;
        else
            pel = int'(rp);
        if (cfg_avg)
            pel = (int'(dp) + pel + 1) >> 1;

        above_left_pel = hpmc_pkg::pixel_t'(above);
        prev_row[col] = rp;
        left_pel = rp;

        if (win_end)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else if (row_end)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 31;
        end
        else
        begin
            col_pos = (col_pos + 1) & 31;
        end

        if (emits)
            expected_pels.push_back('{pel: hpmc_pkg::pixel_t'(pel), last: win_end});
    endtask

    task automatic send_pixel(input hpmc_pkg::pixel_t rp, input hpmc_pkg::pixel_t dp);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            ref_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ref_ch.valid      <= 1'b1;
        ref_ch.ref_pixel  <= rp;
        ref_ch.dest_pixel <= dp;
        @(posedge clk);
        while (!ref_ch.ready)
            @(posedge clk);
        predict_pel(rp, dp);
        words_sent++;
    endtask

    // Hold the input off until every prediction is out, then let the pipe settle
    task automatic drain_results();
        ref_ch.valid <= 1'b0;
        while (expected_pels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hpmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hpmc_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            hpmc_pkg::REG_WIDE_BLOCK:   cfg_wide  = val[0];
            hpmc_pkg::REG_HEIGHT_CODE:  cfg_hcode = val;
            hpmc_pkg::REG_HALF_X:       cfg_hx    = val[0];
            hpmc_pkg::REG_HALF_Y:       cfg_hy    = val[0];
            hpmc_pkg::REG_AVERAGE_MODE: cfg_avg   = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic wide, input logic [1:0] hcode,
                              input logic hx, input logic hy, input logic avg);
        write_reg(hpmc_pkg::REG_WIDE_BLOCK, {1'b0, wide});
        write_reg(hpmc_pkg::REG_HEIGHT_CODE, hcode);
        write_reg(hpmc_pkg::REG_HALF_X, {1'b0, hx});
        write_reg(hpmc_pkg::REG_HALF_Y, {1'b0, hy});
        write_reg(hpmc_pkg::REG_AVERAGE_MODE, {1'b0, avg});
        cfg_we <= 1'b0;
    endtask

    task automatic set_random_config();
        logic [1:0] hcode;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            hcode = hpmc_pkg::HEIGHT_4;
        else if (r < 8)
            hcode = hpmc_pkg::HEIGHT_8;
        else if (r == 8)
            hcode = hpmc_pkg::HEIGHT_16;
        else
            hcode = HEIGHT_RESERVED;
        set_config($urandom_range(0, 4) == 0, hcode, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic finish_window();
        while (col_pos != 0 || row_pos != 0)
            send_pixel(rand_pixel(), rand_pixel());
    endtask

    task automatic run_window(input int lead);
        repeat (lead) send_pixel(rand_pixel(), rand_pixel());
        finish_window();
    endtask

    // Reset geometry: 8 by 8 plain copy, nothing written yet
    task automatic test_reset_geometry();
        src_gaps_on  = 1'b0;
        snk_stall_on = 1'b0;
        run_window(1);
        drain_results();
    endtask

    // Widest four-point window with averaging; also fills every row store entry
    task automatic test_extreme_window();
        hpmc_pkg::pixel_t rp;
        hpmc_pkg::pixel_t dp;
        set_config(1'b1, hpmc_pkg::HEIGHT_4, 1'b1, 1'b1, 1'b1);
        src_gaps_on  = 1'b1;
        snk_stall_on = 1'b1;
        for (int r = 0; r < hpmc_pkg::BLK_H_SHORT + 1; r++)
        begin
            for (int c = 0; c < hpmc_pkg::BLK_W_WIDE + 1; c++)
            begin
                if (r < 2)
                    rp = 8'hFF;
                else if (r < 4)
                    rp = ((r + c) & 1) ? 8'hFF : 8'h00;
                else
                    rp = (c & 1) ? 8'hFE : 8'h01;
                dp = (c < 8) ? 8'hFF : 8'h00;
                send_pixel(rp, dp);
            end
        end
        drain_results();
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 8; m++)
        begin
            set_config(1'b0, hpmc_pkg::HEIGHT_4, m[0], m[1], m[2]);
            src_gaps_on  = m[0];
            snk_stall_on = m[1];
            run_window(1);
            drain_results();
        end
    endtask

    task automatic test_height_codes();
        set_config(1'b0, hpmc_pkg::HEIGHT_8, 1'b1, 1'b0, 1'b0);
        run_window(1);
        drain_results();
        set_config(1'b0, hpmc_pkg::HEIGHT_16, 1'b0, 1'b1, 1'b1);
        run_window(1);
        drain_results();
        set_config(1'b0, HEIGHT_RESERVED, 1'b1, 1'b1, 1'b0);
        run_window(1);
        drain_results();
    endtask

    // Change geometry partway through a window; counters clamp to the new edges
    task automatic test_mid_window_change();
        src_gaps_on  = 1'b1;
        snk_stall_on = 1'b1;
        set_config(1'b1, hpmc_pkg::HEIGHT_16, 1'b1, 1'b1, 1'b0);
        repeat (40) send_pixel(rand_pixel(), rand_pixel());
        drain_results();
        set_config(1'b0, hpmc_pkg::HEIGHT_4, 1'b0, 1'b1, 1'b1);
        finish_window();
        drain_results();
        set_config(1'b1, hpmc_pkg::HEIGHT_8, 1'b1, 1'b0, 1'b1);
        repeat (30) send_pixel(rand_pixel(), rand_pixel());
        drain_results();
        set_config(1'b0, hpmc_pkg::HEIGHT_4, 1'b1, 1'b1, 1'b0);
        finish_window();
        drain_results();
        set_config(1'b0, hpmc_pkg::HEIGHT_4, 1'b0, 1'b0, 1'b0);
        repeat (5) send_pixel(rand_pixel(), rand_pixel());
        drain_results();
        set_config(1'b1, hpmc_pkg::HEIGHT_4, 1'b1, 1'b1, 1'b1);
        finish_window();
        drain_results();
        regeometries += 3;
    endtask

    task automatic test_random_traffic();
        int start;
        int r;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            snk_stall_on = ($urandom_range(0, 3) != 0);
            set_random_config();
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                repeat ($urandom_range(1, 30)) send_pixel(rand_pixel(), rand_pixel());
                drain_results();
                set_random_config();
                finish_window();
                regeometries++;
            end
            else if (r == 1)
            begin
                // pause partway through until the output side has caught up
                repeat ($urandom_range(1, 20)) send_pixel(rand_pixel(), rand_pixel());
                drain_results();
                finish_window();
            end
            else
            begin
                repeat ($urandom_range(1, 3)) run_window(1);
            end
            drain_results();
        end
    endtask

    initial
    begin
        pred_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = snk_stall_on ? pick_gap() : 0;
            if (stall > 0)
            begin
                pred_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pred_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_pred
        pred_word_t want;
        if (rst_n && pred_ch.valid && pred_ch.ready)
        begin
            if (expected_pels.size() == 0)
            begin
                $display("%0t: unexpected word: pred_pixel %0d block_end %0b",
                         $time, pred_ch.pred_pixel, pred_ch.block_end);
                mismatches++;
            end
            else
            begin
                want = expected_pels.pop_front();
                pels_checked++;
                if (pred_ch.pred_pixel !== want.pel)
                begin
                    $display("%0t: pred_pixel expected %0d, actual %0d",
                             $time, want.pel, pred_ch.pred_pixel);
                    mismatches++;
                end
                if (pred_ch.block_end !== want.last)
                begin
                    $display("%0t: block_end expected %0b, actual %0b",
                             $time, want.last, pred_ch.block_end);
                    mismatches++;
                end
                if (want.last)
                    windows_seen++;
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("%0t: run did not finish in time", $time);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        foreach (prev_row[i])
            prev_row[i] = '0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        ref_ch.valid      <= 1'b0;
        ref_ch.ref_pixel  <= '0;
        ref_ch.dest_pixel <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_extreme_window();
        test_each_mode();
        test_height_codes();
        test_mid_window_change();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        $display("Streamed %0d reference words over %0d complete windows, %0d predictions checked.",
                 words_sent, windows_seen, pels_checked);
        $display("All interpolation and averaging modes, all height codes, %0d geometry changes.",
                 regeometries);
        if (mismatches == 0 && expected_pels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hpmc_pkg.sv
sv/hpmc_if.sv
sv/hpmc_interp.sv
sv/halfpel_motion_compensation.sv
tb/tb_top.sv
